// File: design/fskpt_pkg.sv
// Package: shared types and constants of the FSK packet transmitter.
package fskpt_pkg;

  // Field widths
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned AMP_W    = 31;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SYNC_W   = 8;
  localparam int unsigned EPP_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Packet bookkeeping widths
  localparam int unsigned CNT_W  = 7;   // events in one packet, up to 85
  localparam int unsigned BIDX_W = 12;  // bit index inside a packet
  localparam int unsigned BYTE_W = 9;   // byte index inside a packet
  localparam int unsigned CRC_W  = 16;

  // CRC-16-CCITT
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // Register reset values
  localparam logic [PERIOD_W-1:0] ZERO_PERIOD_RST  = 16'd4;
  localparam logic [PERIOD_W-1:0] ONE_PERIOD_RST   = 16'd2;
  localparam logic [PERIOD_W-1:0] PAUSE_PERIOD_RST = 16'd8;
  localparam logic [AMP_W-1:0]    AMPLITUDE_RST    = 31'd1048576;
  localparam logic [SYNC_W-1:0]   SYNC_FIRST_RST   = 8'd170;
  localparam logic [SYNC_W-1:0]   SYNC_SECOND_RST  = 8'd85;
  localparam logic [EPP_W-1:0]    EPP_RST          = 5'd16;

  // Symbol codes
  typedef enum logic [1:0] {
    SYM_ZERO  = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_PAUSE = 2'd2
  } sym_e;

  // Input operations
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_PERIOD  = 3'd0,
    CFG_ONE_PERIOD   = 3'd1,
    CFG_PAUSE_PERIOD = 3'd2,
    CFG_AMPLITUDE    = 3'd3,
    CFG_SYNC_FIRST   = 3'd4,
    CFG_SYNC_SECOND  = 3'd5,
    CFG_EPP          = 3'd6
  } cfg_idx_e;

  // Framing settings seen by the framer
  typedef struct packed {
    logic [SYNC_W-1:0] sync_first;
    logic [SYNC_W-1:0] sync_second;
    logic [EPP_W-1:0]  events_per_packet;
  } frm_cfg_t;

  // Request from the tick logic to the framer
  typedef struct packed {
    logic              pick;
    logic              push;
    logic [WORD_W-1:0] word;
  } frm_req_t;

  // Framer answer for the current request
  typedef struct packed {
    sym_e kind;
    logic dropped;
  } frm_rsp_t;

endpackage

// File: design/fskpt_if.sv
// Interfaces: input request, result and configuration write channels.
interface fskpt_in_if;
  import fskpt_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [WORD_W-1:0] event_word;

  modport source (output valid, output op, output event_word, input ready);
  modport sink   (input valid, input op, input event_word, output ready);
endinterface

interface fskpt_out_if;
  import fskpt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       symbol_start;
  logic [1:0]                 symbol_kind;
  logic                       push_dropped;

  modport source (output valid, output sample, output symbol_start, output symbol_kind,
                  output push_dropped, input ready);
  modport sink   (input valid, input sample, input symbol_start, input symbol_kind,
                  input push_dropped, output ready);
endinterface

interface fskpt_cfg_if;
  import fskpt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/fskpt_framer.sv
// Framer: event queue and packet bit sequencer with bit-serial CRC.
module fskpt_framer
  import fskpt_pkg::*;
#(
  parameter int unsigned MAX_EVENTS  = 16,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  frm_cfg_t cfg_i,
  input  frm_req_t req_i,
  output frm_rsp_t rsp_o
);

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = FILL_W + 1;
  localparam int unsigned CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

  // Queue storage and read data register
  logic [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  // Queue pointers
  logic [PTR_W-1:0]  head_q, tail_q, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q;

  // Packet state
  logic [CNT_W-1:0]  n_q;
  logic [BIDX_W-1:0] idx_q;
  logic [CRC_W-1:0]  crc_q;
  logic [1:0]        byte_sel_q;

  // Combinational terms
  logic [BIDX_W-1:0] pkt_bits;
  logic              pkt_done;
  logic              restart;
  logic [CMP_W-1:0]  drain_w;
  logic [FILL_W-1:0] drain;
  logic [SUM_W-1:0]  head_sum, head_wrap;
  logic [PTR_W-1:0]  head_after;
  logic [FILL_W-1:0] fill_after;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  n_new;
  logic [CNT_W-1:0]  n_eff;
  logic [BIDX_W-1:0] idx_eff;
  logic [CRC_W-1:0]  crc_eff, crc_fed, crc_next;
  logic [BYTE_W-1:0] cur_byte, pay_end;
  logic [2:0]        bpos;
  logic              is_pay, is_evt;
  logic [SYNC_W-1:0] byte_val;
  logic [BIDX_W-1:0] crc_k;
  logic              bit_val;
  logic              go_pause;
  logic              full;

  // Detect packet end and work out the next packet
  always_comb begin
    pkt_bits   = BIDX_W'(40) + BIDX_W'(n_q) * BIDX_W'(24);
    pkt_done   = (n_q == '0) || (idx_q >= pkt_bits);
    restart    = req_i.pick && pkt_done;
    drain_w    = (CMP_W'(n_q) > CMP_W'(fill_q)) ? CMP_W'(fill_q) : CMP_W'(n_q);
    drain      = FILL_W'(drain_w);
    head_sum   = SUM_W'(head_q) + SUM_W'(drain);
    head_wrap  = (head_sum >= SUM_W'(QUEUE_DEPTH)) ? head_sum - SUM_W'(QUEUE_DEPTH)
                                                   : head_sum;
    head_after = head_wrap[PTR_W-1:0];
    fill_after = fill_q - drain;
    if (cfg_i.events_per_packet == '0) begin
      limit = CNT_W'(1);
    end else if (CNT_W'(cfg_i.events_per_packet) > CNT_W'(MAX_EVENTS)) begin
      limit = CNT_W'(MAX_EVENTS);
    end else begin
      limit = CNT_W'(cfg_i.events_per_packet);
    end
    n_new    = (CMP_W'(fill_after) < CMP_W'(limit)) ? CNT_W'(fill_after) : limit;
    go_pause = restart && (n_new == '0);
  end

  // Choose the packet bit for this symbol
  always_comb begin
    n_eff   = restart ? n_new : n_q;
    idx_eff = restart ? '0 : idx_q;
    crc_eff = restart ? CRC_INIT : crc_q;
    cur_byte = idx_eff[BIDX_W-1:3];
    bpos     = idx_eff[2:0];
    pay_end  = BYTE_W'(3) + BYTE_W'(n_eff) * BYTE_W'(3);
    is_pay   = (cur_byte >= BYTE_W'(2)) && (cur_byte < pay_end);
    is_evt   = is_pay && (cur_byte >= BYTE_W'(3));
    case (byte_sel_q)
      2'd0:    byte_val = rd_data_q[23:16];
      2'd1:    byte_val = rd_data_q[15:8];
      default: byte_val = rd_data_q[7:0];
    endcase
    if (cur_byte == BYTE_W'(2)) begin
      byte_val = SYNC_W'(BYTE_W'(n_eff) * BYTE_W'(3));
    end
    crc_k = idx_eff - {pay_end, 3'b000};
    if (cur_byte == BYTE_W'(0)) begin
      bit_val = cfg_i.sync_first[3'd7 - bpos];
    end else if (cur_byte == BYTE_W'(1)) begin
      bit_val = cfg_i.sync_second[3'd7 - bpos];
    end else if (is_pay) begin
      bit_val = byte_val[3'd7 - bpos];
    end else begin
      bit_val = crc_eff[4'd15 - crc_k[3:0]];
    end
    crc_fed  = {crc_eff[CRC_W-2:0], 1'b0} ^ ((crc_eff[CRC_W-1] ^ bit_val) ? CRC_POLY : '0);
    crc_next = is_pay ? crc_fed : crc_eff;
    full     = (fill_q == FILL_W'(QUEUE_DEPTH));
    if (go_pause) begin
      rsp_o.kind = SYM_PAUSE;
    end else begin
      rsp_o.kind = bit_val ? SYM_ONE : SYM_ZERO;
    end
    rsp_o.dropped = req_i.push && full;
  end

  // Point the read port at the event word needed by the next symbol
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (restart) begin
      rd_ptr_d = head_after;
    end else if (req_i.pick && is_evt && (bpos == 3'd7) && (byte_sel_q == 2'd2)) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
  end

  // Advance packet state on each chosen symbol
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= '0;
      idx_q      <= '0;
      crc_q      <= CRC_INIT;
      byte_sel_q <= '0;
      rd_ptr_q   <= '0;
    end else if (req_i.pick) begin
      n_q      <= n_eff;
      crc_q    <= crc_next;
      idx_q    <= go_pause ? '0 : idx_eff + BIDX_W'(1);
      rd_ptr_q <= rd_ptr_d;
      if (restart) begin
        byte_sel_q <= '0;
      end else if (is_evt && (bpos == 3'd7)) begin
        if (byte_sel_q == 2'd2) begin
          byte_sel_q <= '0;
        end else begin
          byte_sel_q <= byte_sel_q + 2'd1;
        end
      end
    end
  end

  // Update queue pointers on drain and push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (restart) begin
      head_q <= head_after;
      fill_q <= fill_after;
    end else if (req_i.push && !full) begin
      tail_q <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
      fill_q <= fill_q + FILL_W'(1);
    end
  end

  // Write pushed events, fetch the event word for the next symbol every cycle
  always_ff @(posedge clk_i) begin
    if (req_i.push && !full) begin
      mem[tail_q] <= req_i.word;
    end
    rd_data_q <= mem[rd_ptr_d];
  end

endmodule

// File: design/fsk_packet_transmitter.sv
// Top level: square-wave FSK packet transmitter with CRC-16-CCITT framing.
//
// Channels: in_i takes requests, each either a sample tick (op 0) or an event
// word to queue (op 1). out_o returns one result per request: the sample level
// (+/- amplitude), whether the tick began a new symbol, the current symbol kind
// and whether a pushed event was dropped because the queue was full. cfg_i
// writes the seven settings by index; writes are always ready and indexes past
// the last register are ignored.
// Throughput is one request per cycle while out_o is not stalled. A request
// is captured in the input register, then evaluated into the result register.
// Symbol choice, CRC update and queue bookkeeping all settle in that one step;
// event words are read from the queue memory ahead of use through a
// registered read port.
// Reset empties the queue, sets pause symbols with positive polarity and
// restores the register defaults; the queue memory is not cleared.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; after that in_i.ready drops until out_o drains.
module fsk_packet_transmitter
  import fskpt_pkg::*;
#(
  parameter int unsigned MAX_EVENTS  = 16,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fskpt_in_if.sink     in_i,
  fskpt_out_if.source  out_o,
  fskpt_cfg_if.sink    cfg_i
);

  // Settings
  logic [PERIOD_W-1:0] zero_period_q, one_period_q, pause_period_q;
  logic [AMP_W-1:0]    amplitude_q;
  logic [SYNC_W-1:0]   sync_first_q, sync_second_q;
  logic [EPP_W-1:0]    epp_q;

  // Input register
  logic              in_vld_q;
  logic              op_q;
  logic [WORD_W-1:0] word_q;

  // Modulator state
  logic                pol_q, pol_d;
  logic [PERIOD_W-1:0] hold_q, hold_d;
  sym_e                sym_q, sym_d;
  logic                start_d;
  logic [PERIOD_W-1:0] period;

  // Result register
  logic                       out_vld_q;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       start_q;
  sym_e                       kind_q;
  logic                       drop_q;

  logic     advance, process;
  frm_cfg_t frm_cfg;
  frm_req_t frm_req;
  frm_rsp_t frm_rsp;

  assign advance    = !out_vld_q || out_o.ready;
  assign process    = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_period_q  <= ZERO_PERIOD_RST;
      one_period_q   <= ONE_PERIOD_RST;
      pause_period_q <= PAUSE_PERIOD_RST;
      amplitude_q    <= AMPLITUDE_RST;
      sync_first_q   <= SYNC_FIRST_RST;
      sync_second_q  <= SYNC_SECOND_RST;
      epp_q          <= EPP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ZERO_PERIOD:  zero_period_q  <= cfg_i.data[PERIOD_W-1:0];
        CFG_ONE_PERIOD:   one_period_q   <= cfg_i.data[PERIOD_W-1:0];
        CFG_PAUSE_PERIOD: pause_period_q <= cfg_i.data[PERIOD_W-1:0];
        CFG_AMPLITUDE:    amplitude_q    <= cfg_i.data[AMP_W-1:0];
        CFG_SYNC_FIRST:   sync_first_q   <= cfg_i.data[SYNC_W-1:0];
        CFG_SYNC_SECOND:  sync_second_q  <= cfg_i.data[SYNC_W-1:0];
        CFG_EPP:          epp_q          <= cfg_i.data[EPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (process) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.op;
      word_q <= in_i.event_word;
    end
  end

  // Framer request
  assign frm_cfg.sync_first        = sync_first_q;
  assign frm_cfg.sync_second       = sync_second_q;
  assign frm_cfg.events_per_packet = epp_q;
  assign frm_req.pick = process && (op_q == OP_TICK) && (hold_q == '0);
  assign frm_req.push = process && (op_q == OP_PUSH);
  assign frm_req.word = word_q;

  fskpt_framer #(
    .MAX_EVENTS  (MAX_EVENTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (frm_cfg),
    .req_i  (frm_req),
    .rsp_o  (frm_rsp)
  );

  // Step the symbol timer and polarity on a tick
  always_comb begin
    pol_d   = pol_q;
    sym_d   = sym_q;
    hold_d  = hold_q;
    start_d = 1'b0;
    case (frm_rsp.kind)
      SYM_ZERO: period = zero_period_q;
      SYM_ONE:  period = one_period_q;
      default:  period = pause_period_q;
    endcase
    if (process && (op_q == OP_TICK)) begin
      if (hold_q == '0) begin
        pol_d   = !pol_q;
        sym_d   = frm_rsp.kind;
        hold_d  = (period == '0) ? '0 : period - PERIOD_W'(1);
        start_d = 1'b1;
      end else begin
        hold_d = hold_q - PERIOD_W'(1);
      end
    end
    sample_d = pol_d ? -$signed({1'b0, amplitude_q}) : $signed({1'b0, amplitude_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q  <= 1'b0;
      hold_q <= PERIOD_W'(1);
      sym_q  <= SYM_PAUSE;
    end else begin
      pol_q  <= pol_d;
      hold_q <= hold_d;
      sym_q  <= sym_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (process) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      sample_q <= sample_d;
      start_q  <= start_d;
      kind_q   <= sym_d;
      drop_q   <= frm_rsp.dropped;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.sample       = sample_q;
  assign out_o.symbol_start = start_q;
  assign out_o.symbol_kind  = kind_q;
  assign out_o.push_dropped = drop_q;

endmodule

// File: bench/fsk_packet_transmitter_test.sv
// Testbench: self-checking stimulus and checker for the FSK packet transmitter.
module fsk_packet_transmitter_test;
  import fskpt_pkg::*;

  localparam int unsigned MAX_EVENTS   = 16;
  localparam int unsigned QUEUE_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned REPORT_LINES = 100;
  localparam int unsigned HOLDOFF_LEN  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // past the last register

  // One expected result of one request
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start;
    sym_e                       kind;
    logic                       dropped;
  } tone_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    DRAIN_ALL,
    DRAIN_MOST,
    DRAIN_FEW,
    DRAIN_EVERY_FIFTH
  } drain_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  fskpt_in_if  in_ch ();
  fskpt_out_if out_ch ();
  fskpt_cfg_if cfg_ch ();

  fsk_packet_transmitter #(
    .MAX_EVENTS (MAX_EVENTS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always #1 clk_i = ~clk_i;

  // Predicted settings
  logic [PERIOD_W-1:0] cfg_zero, cfg_one, cfg_pause;
  logic [AMP_W-1:0]    cfg_amp;
  logic [SYNC_W-1:0]   cfg_sync_a, cfg_sync_b;
  logic [EPP_W-1:0]    cfg_epp;

  // Predicted modulator and framer state
  logic                level_negative;
  logic [PERIOD_W-1:0] hold_left;
  sym_e                cur_sym;
  logic [BIDX_W-1:0]   bit_idx;
  int                  pkt_count;
  logic [CRC_W-1:0]    crc;
  logic [WORD_W-1:0]   event_mem [QUEUE_DEPTH];
  int                  q_head, q_tail, q_fill;

  tone_t expected_tones[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    burst_left = 0;
  int    hold_cycles = 0;
  logic  steady = 1'b0;

  // Choose the next symbol of the packet stream, starting a new packet when due
  function automatic sym_e choose_symbol();
    int                n;
    int                limit;
    int                byte_no;
    int                pos;
    int                payload_end;
    int                k;
    logic [7:0]        value;
    logic [WORD_W-1:0] word;
    logic              b;
    logic              fb;
    n = pkt_count;
    if (n == 0 || bit_idx >= 8 * (5 + 3 * n)) begin
      // retire the finished packet's events
      if (n > 0) begin
        if (n > q_fill) n = q_fill;
        q_head = (q_head + n) % QUEUE_DEPTH;
        q_fill -= n;
      end
      limit = (cfg_epp == 0) ? 1 : ((cfg_epp > MAX_EVENTS) ? MAX_EVENTS : cfg_epp);
      n = (q_fill < limit) ? q_fill : limit;
      pkt_count = n;
      bit_idx = '0;
      crc = CRC_INIT;
      if (n == 0) return SYM_PAUSE;
    end
    byte_no = bit_idx >> 3;
    pos = 7 - bit_idx[2:0];
    payload_end = 3 + 3 * n;
    if (byte_no == 0) begin
      b = cfg_sync_a[pos];
    end else if (byte_no == 1) begin
      b = cfg_sync_b[pos];
    end else if (byte_no < payload_end) begin
      if (byte_no == 2) begin
        k = 3 * n;
        value = k[7:0];
      end else begin
        k = byte_no - 3;
        word = event_mem[(q_head + k / 3) % QUEUE_DEPTH];
        value = word[(2 - k % 3) * 8 +: 8];
      end
      b = value[pos];
      // fold the bit into the CRC
      fb = crc[CRC_W-1] ^ b;
      crc = {crc[CRC_W-2:0], 1'b0};
      if (fb) crc = crc ^ CRC_POLY;
    end else begin
      k = bit_idx - 8 * payload_end;
      b = (k < 16) ? crc[15 - k] : 1'b0;
    end
    bit_idx = bit_idx + 1'b1;
    return b ? SYM_ONE : SYM_ZERO;
  endfunction

  function automatic logic [PERIOD_W-1:0] symbol_period(sym_e s);
    logic [PERIOD_W-1:0] p;
    case (s)
      SYM_ZERO: p = cfg_zero;
      SYM_ONE:  p = cfg_one;
      default:  p = cfg_pause;
    endcase
    return (p == 0) ? 16'd1 : p;
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic tone_t predict_tone(logic op, logic [WORD_W-1:0] word);
    tone_t                      t;
    logic signed [SAMPLE_W-1:0] level;
    t.start = 1'b0;
    t.dropped = 1'b0;
    if (op == OP_PUSH) begin
      if (q_fill >= QUEUE_DEPTH) begin
        t.dropped = 1'b1;
      end else begin
        event_mem[q_tail] = word;
        q_tail = (q_tail + 1) % QUEUE_DEPTH;
        q_fill++;
      end
    end else begin
      if (hold_left == 0) begin
        level_negative = ~level_negative;
        cur_sym = choose_symbol();
        hold_left = symbol_period(cur_sym);
        t.start = 1'b1;
      end
      hold_left = hold_left - 1'b1;
    end
    level = {1'b0, cfg_amp};
    t.sample = level_negative ? -level : level;
    t.kind = cur_sym;
    return t;
  endfunction

  // Track accepted register writes and requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_ZERO_PERIOD:  cfg_zero   = cfg_ch.data[PERIOD_W-1:0];
          CFG_ONE_PERIOD:   cfg_one    = cfg_ch.data[PERIOD_W-1:0];
          CFG_PAUSE_PERIOD: cfg_pause  = cfg_ch.data[PERIOD_W-1:0];
          CFG_AMPLITUDE:    cfg_amp    = cfg_ch.data[AMP_W-1:0];
          CFG_SYNC_FIRST:   cfg_sync_a = cfg_ch.data[SYNC_W-1:0];
          CFG_SYNC_SECOND:  cfg_sync_b = cfg_ch.data[SYNC_W-1:0];
          CFG_EPP:          cfg_epp    = cfg_ch.data[EPP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_tones.push_back(predict_tone(in_ch.op, in_ch.event_word));
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < REPORT_LINES) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    tone_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_tones.size() == 0) begin
        report_mismatch("unexpected result", out_ch.sample, 32'd0);
      end else begin
        want = expected_tones.pop_front();
        if (out_ch.sample !== want.sample) begin
          report_mismatch("sample", out_ch.sample, want.sample);
        end
        if (out_ch.symbol_start !== want.start) begin
          report_mismatch("symbol_start", 32'(out_ch.symbol_start), 32'(want.start));
        end
        if (out_ch.symbol_kind !== want.kind) begin
          report_mismatch("symbol_kind", 32'(out_ch.symbol_kind), 32'(want.kind));
        end
        if (out_ch.push_dropped !== want.dropped) begin
          report_mismatch("push_dropped", 32'(out_ch.push_dropped), 32'(want.dropped));
        end
      end
    end
  end

  // Stall the result channel on a changing pattern, or hold off when asked
  drain_e drain_mode = DRAIN_ALL;
  int     drain_left = 0;
  int     drain_tick = 0;
  always @(negedge clk_i) begin
    if (drain_left == 0) begin
      drain_mode = drain_e'($urandom_range(0, 3));
      drain_left = $urandom_range(20, 80);
    end
    drain_left--;
    drain_tick++;
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else if (steady) begin
      out_ch.ready <= 1'b1;
    end else begin
      case (drain_mode)
        DRAIN_ALL:  out_ch.ready <= 1'b1;
        DRAIN_MOST: out_ch.ready <= ($urandom_range(0, 3) != 0);
        DRAIN_FEW:  out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:    out_ch.ready <= (drain_tick % 5 != 0);
      endcase
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] random_word();
    logic [31:0] r;
    r = $urandom();
    return r[WORD_W-1:0];
  endfunction

  // Fill the bits above a register's width with noise
  function automatic logic [CFG_DATA_W-1:0] spill(int unsigned width, int unsigned value);
    logic [31:0] r;
    logic [31:0] mask;
    r = $urandom();
    mask = (32'd1 << width) - 32'd1;
    r = (r & ~mask) | (value & mask);
    return r[CFG_DATA_W-1:0];
  endfunction

  // Offer one request, in bursts with random gaps; returns at a falling edge
  task automatic send_request(op_e op, logic [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.event_word <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_tones.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Reset hold of one tick, then one long pause symbol that needs the upper period bits
  task automatic test_long_hold();
    steady = 1'b1;
    write_register(CFG_PAUSE_PERIOD, spill(PERIOD_W, 16'd300));
    write_register(CFG_ZERO_PERIOD, spill(PERIOD_W, 16'hFFFF));
    send_request(OP_TICK, random_word());
    send_request(OP_TICK, random_word());
    while (hold_left != 0) send_request(OP_TICK, random_word());
    wait_drain();
    steady = 1'b0;
  endtask

  // Field extremes, zero periods and amplitude, clamped packet size, spare index
  task automatic test_directed();
    write_register(CFG_ZERO_PERIOD, spill(PERIOD_W, 0));
    write_register(CFG_ONE_PERIOD, spill(PERIOD_W, 1));
    write_register(CFG_PAUSE_PERIOD, spill(PERIOD_W, 1));
    write_register(CFG_AMPLITUDE, 31'd0);
    write_register(CFG_SYNC_FIRST, spill(SYNC_W, 8'hFF));
    write_register(CFG_SYNC_SECOND, spill(SYNC_W, 8'h00));
    write_register(CFG_EPP, spill(EPP_W, 0));
    write_register(CFG_SPARE, spill(0, 0));
    send_request(OP_PUSH, 24'hFFFFFF);
    send_request(OP_PUSH, 24'h000000);
    repeat (8) send_request(OP_TICK, 24'hFFFFFF);
    send_request(OP_PUSH, 24'h800001);
    repeat (10) send_request(OP_TICK, 24'h000000);
    wait_drain();
  endtask

  // Random settings per phase; push short event bursts, then tick them out
  task automatic test_random_packets();
    int               sent;
    int               pushes;
    int               ticks;
    logic [AMP_W-1:0] amp_pick;
    for (int phase = 0; phase < 5; phase++) begin
      write_register(CFG_ZERO_PERIOD, spill(PERIOD_W,
          ($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2)));
      write_register(CFG_ONE_PERIOD, spill(PERIOD_W,
          ($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2)));
      write_register(CFG_PAUSE_PERIOD, spill(PERIOD_W, $urandom_range(0, 6)));
      case ($urandom_range(0, 3))
        0:       amp_pick = 31'd1;
        1:       amp_pick = 31'h7FFF_FFFF;
        2:       amp_pick = 31'd0;
        default: amp_pick = AMP_W'($urandom());
      endcase
      write_register(CFG_AMPLITUDE, amp_pick);
      write_register(CFG_SYNC_FIRST, spill(SYNC_W, $urandom_range(0, 255)));
      write_register(CFG_SYNC_SECOND, spill(SYNC_W, $urandom_range(0, 255)));
      case ($urandom_range(0, 3))
        0:       write_register(CFG_EPP, spill(EPP_W, $urandom_range(4, 16)));
        1:       write_register(CFG_EPP, spill(EPP_W, $urandom_range(17, 31)));
        default: write_register(CFG_EPP, spill(EPP_W, $urandom_range(0, 3)));
      endcase
      sent = 0;
      while (sent < 200) begin
        pushes = $urandom_range(0, 3);
        ticks = $urandom_range(10, 60);
        repeat (pushes) send_request(OP_PUSH, random_word());
        repeat (ticks) send_request(OP_TICK, random_word());
        sent += pushes + ticks;
      end
      wait_drain();
    end
  endtask

  // Push past the queue depth so the surplus is dropped, then tick on
  task automatic test_queue_overflow();
    write_register(CFG_AMPLITUDE, 31'h7FFF_FFFF);
    write_register(CFG_EPP, spill(EPP_W, 31));
    write_register(CFG_ONE_PERIOD, spill(PERIOD_W, 1));
    repeat (QUEUE_DEPTH + 8) send_request(OP_PUSH, random_word());
    repeat (40) send_request(OP_TICK, random_word());
    wait_drain();
  endtask

  // Hold off the receiver while requests keep coming, so the input stalls
  task automatic test_backpressure();
    steady = 1'b1;
    hold_cycles = HOLDOFF_LEN;
    repeat (60) begin
      if ($urandom_range(0, 3) == 0) send_request(OP_PUSH, random_word());
      else send_request(OP_TICK, random_word());
    end
    wait_drain();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_TICK;
    in_ch.event_word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    // register defaults and idle state after reset
    cfg_zero = ZERO_PERIOD_RST;
    cfg_one = ONE_PERIOD_RST;
    cfg_pause = PAUSE_PERIOD_RST;
    cfg_amp = AMPLITUDE_RST;
    cfg_sync_a = SYNC_FIRST_RST;
    cfg_sync_b = SYNC_SECOND_RST;
    cfg_epp = EPP_RST;
    level_negative = 1'b0;
    hold_left = 16'd1;
    cur_sym = SYM_PAUSE;
    bit_idx = '0;
    pkt_count = 0;
    crc = CRC_INIT;
    q_head = 0;
    q_tail = 0;
    q_fill = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_long_hold();
    test_directed();
    test_random_packets();
    test_queue_overflow();
    test_backpressure();

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/fskpt_pkg.sv
design/fskpt_if.sv
design/fskpt_framer.sv
design/fsk_packet_transmitter.sv
bench/fsk_packet_transmitter_test.sv
